/* rtl/psc_pkg.sv */
// Shared constants and codes for the plane side classifier.
`default_nettype none

package psc_pkg;

  // Fixed-point format of coordinates, normal and offset.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned PROD_W    = 2 * COORD_W;
  // Distance width: three full products plus the scaled offset, with sign headroom.
  localparam int unsigned DIST_W    = PROD_W + 2;

  // Command codes.
  localparam logic [1:0] CMD_POINT  = 2'd0;
  localparam logic [1:0] CMD_SPHERE = 2'd1;
  localparam logic [1:0] CMD_BOX    = 2'd2;

  // Side codes.
  localparam logic [1:0] SIDE_BACK  = 2'd0;
  localparam logic [1:0] SIDE_FRONT = 2'd1;
  localparam logic [1:0] SIDE_ON    = 2'd2;
  localparam logic [1:0] SIDE_CLIP  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_NORMAL_X  = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_TOLERANCE = 3'd4;

  // Reset values.
  localparam logic [COORD_W-1:0] NORMAL_Z_RESET = COORD_W'(1) << FRAC_BITS;
  localparam logic [30:0]        TOL_RESET      = 31'd66;

endpackage

`default_nettype wire

/* rtl/plane_side_classifier.sv */
// Top level of the plane side classifier: a five-stage pipeline.
`default_nettype none

// Classifies a point, sphere or axis-aligned box against the configured plane
// (normal . p + offset, all signed Q16.16, evaluated exactly). A word is taken
// on every cycle that start is high; busy is always low. The result appears on
// out_side with out_valid high once the word has passed every pipeline register,
// one result per word, in order, at one word per clock. The pipeline stages are
// corner select, six parallel 32x32 multipliers, two adder levels, and the
// band compare into the output register. The receiver cannot
// stall, so there is no backpressure path. Write configuration only while the
// pipeline is empty.
module plane_side_classifier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_a_x,
  input  wire logic [31:0] in_a_y,
  input  wire logic [31:0] in_a_z,
  input  wire logic [31:0] in_b_x,
  input  wire logic [31:0] in_b_y,
  input  wire logic [31:0] in_b_z,
  input  wire logic [30:0] in_radius,
  // Result channel
  output logic             out_valid,
  output logic [1:0]       out_side,
  // Configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned CW = psc_pkg::COORD_W;
  localparam int unsigned PW = psc_pkg::PROD_W;
  localparam int unsigned DW = psc_pkg::DIST_W;

  // Configuration registers.
  logic signed [CW-1:0] nrm_x_r, nrm_y_r, nrm_z_r, offset_r;
  logic [30:0]          tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_x_r  <= '0;
      nrm_y_r  <= '0;
      nrm_z_r  <= psc_pkg::NORMAL_Z_RESET;
      offset_r <= '0;
      tol_r    <= psc_pkg::TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psc_pkg::REG_NORMAL_X:  nrm_x_r  <= cfg_data;
        psc_pkg::REG_NORMAL_Y:  nrm_y_r  <= cfg_data;
        psc_pkg::REG_NORMAL_Z:  nrm_z_r  <= cfg_data;
        psc_pkg::REG_OFFSET:    offset_r <= cfg_data;
        psc_pkg::REG_TOLERANCE: tol_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits travelling with the data.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // Stage 1: pick near and far corners and form the band limit.
  // Point and sphere use the a corner as the near corner.
  logic               pos_x, pos_y, pos_z, is_box;
  logic [CW-1:0]      near_x_nxt, near_y_nxt, near_z_nxt;
  logic [31:0]        lim_nxt;
  logic signed [CW-1:0] near_x_r, near_y_r, near_z_r, far_x_r, far_y_r, far_z_r;
  logic [1:0]         cmd1_r;
  logic [31:0]        lim1_r;

  always_comb begin
    pos_x  = (nrm_x_r > 0);
    pos_y  = (nrm_y_r > 0);
    pos_z  = (nrm_z_r > 0);
    is_box = (in_command == psc_pkg::CMD_BOX);
    near_x_nxt = (!is_box || pos_x) ? in_a_x : in_b_x;
    near_y_nxt = (!is_box || pos_y) ? in_a_y : in_b_y;
    near_z_nxt = (!is_box || pos_z) ? in_a_z : in_b_z;
    if (in_command == psc_pkg::CMD_SPHERE) begin
      lim_nxt = {1'b0, in_radius} + {1'b0, tol_r};
    end else begin
      lim_nxt = {1'b0, tol_r};
    end
  end

  always_ff @(posedge clk) begin
    near_x_r <= near_x_nxt;
    near_y_r <= near_y_nxt;
    near_z_r <= near_z_nxt;
    far_x_r  <= pos_x ? in_b_x : in_a_x;
    far_y_r  <= pos_y ? in_b_y : in_a_y;
    far_z_r  <= pos_z ? in_b_z : in_a_z;
    cmd1_r   <= in_command;
    lim1_r   <= lim_nxt;
  end

  // Stage 2: six products of normal components and corner coordinates.
  logic signed [PW-1:0] pn_x_r, pn_y_r, pn_z_r, pf_x_r, pf_y_r, pf_z_r;
  logic [1:0]           cmd2_r;
  logic [31:0]          lim2_r;

  always_ff @(posedge clk) begin
    pn_x_r <= nrm_x_r * near_x_r;
    pn_y_r <= nrm_y_r * near_y_r;
    pn_z_r <= nrm_z_r * near_z_r;
    pf_x_r <= nrm_x_r * far_x_r;
    pf_y_r <= nrm_y_r * far_y_r;
    pf_z_r <= nrm_z_r * far_z_r;
    cmd2_r <= cmd1_r;
    lim2_r <= lim1_r;
  end

  // Stage 3: first adder level, offset scaled to the product format.
  logic signed [DW-1:0] off_w;
  logic signed [DW-1:0] ns_a_r, ns_b_r, fs_a_r, fs_b_r;
  logic [1:0]           cmd3_r;
  logic [31:0]          lim3_r;

  function automatic logic signed [DW-1:0] sx(input logic [PW-1:0] v);
    return {{(DW - PW){v[PW-1]}}, v};
  endfunction

  assign off_w = {{(DW - CW){offset_r[CW-1]}}, offset_r} <<< psc_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    ns_a_r <= sx(pn_x_r) + sx(pn_y_r);
    ns_b_r <= sx(pn_z_r) + off_w;
    fs_a_r <= sx(pf_x_r) + sx(pf_y_r);
    fs_b_r <= sx(pf_z_r) + off_w;
    cmd3_r <= cmd2_r;
    lim3_r <= lim2_r;
  end

  // Stage 4: final distances.
  logic signed [DW-1:0] dn_r, df_r;
  logic [1:0]           cmd4_r;
  logic [31:0]          lim4_r;

  always_ff @(posedge clk) begin
    dn_r   <= ns_a_r + ns_b_r;
    df_r   <= fs_a_r + fs_b_r;
    cmd4_r <= cmd3_r;
    lim4_r <= lim3_r;
  end

  // Stage 5: band and sign tests into the output register.
  logic signed [DW-1:0] lim_pos, lim_neg;
  logic [1:0]           side_nxt, side_r;

  always_comb begin
    lim_pos  = {{(DW - 32){1'b0}}, lim4_r} <<< psc_pkg::FRAC_BITS;
    lim_neg  = -lim_pos;
    side_nxt = psc_pkg::SIDE_BACK;
    case (cmd4_r)
      psc_pkg::CMD_POINT, psc_pkg::CMD_SPHERE: begin
        if (dn_r < lim_neg) begin
          side_nxt = psc_pkg::SIDE_BACK;
        end else if (dn_r > lim_pos) begin
          side_nxt = psc_pkg::SIDE_FRONT;
        end else if (cmd4_r == psc_pkg::CMD_POINT) begin
          side_nxt = psc_pkg::SIDE_ON;
        end else begin
          side_nxt = psc_pkg::SIDE_CLIP;
        end
      end
      psc_pkg::CMD_BOX: begin
        if (dn_r > 0) begin
          side_nxt = psc_pkg::SIDE_FRONT;
        end else if (df_r > 0) begin
          side_nxt = psc_pkg::SIDE_CLIP;
        end else begin
          side_nxt = psc_pkg::SIDE_BACK;
        end
      end
      default: side_nxt = psc_pkg::SIDE_BACK;
    endcase
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_side  = side_r;

  // Every accepted word leaves the pipeline as a result on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid_r)
    else $error("accepted word did not produce a result after five cycles");

  // No result without a word in the last stage.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !v4_r |=> !out_valid_r)
    else $error("result strobe without a word in flight");

  // Only a point can be on the plane.
  a_on_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && side_r == psc_pkg::SIDE_ON) |-> $past(cmd4_r) == psc_pkg::CMD_POINT)
    else $error("on-plane result for a non-point command");

  // A point is never reported as clipping.
  a_clip_not_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && side_r == psc_pkg::SIDE_CLIP) |-> $past(cmd4_r) != psc_pkg::CMD_POINT)
    else $error("clipping result for a point command");

endmodule

`default_nettype wire
